// File: sv/v3a_pkg.sv
// Shared types, constants and saturation helpers for the three-component vector unit.
package v3a_pkg;

    // Number format
    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int EFF_BITS  = (WORD_BITS > 32) ? 32 : WORD_BITS;

    // Field and bus widths
    localparam int DW        = 32;
    localparam int S_TDATA_W = 7 * DW;
    localparam int M_TDATA_W = 4 * DW;
    localparam int MODE_W    = 3;
    localparam int STAT_W    = 2;

    // Wide accumulator for sums of products
    localparam int ACC_W = 2 * DW + 2;
    localparam int PROD_W = 2 * DW;

    // Square root pipeline
    localparam int SQ_IN_W   = 2 * DW;
    localparam int SQ_STEPS  = SQ_IN_W / 2;
    localparam int SQ_REM_W  = SQ_STEPS + 3;
    localparam int LEN_W     = SQ_STEPS + 1;

    // Divider pipeline
    localparam int DV_W   = LEN_W;
    localparam int DREM_W = DV_W + 1;
    localparam int NUM_W  = DW + FRAC_BITS;
    localparam int DVD_W  = NUM_W + 1;

    localparam logic signed [ACC_W-1:0] SAT_HI   = (ACC_W'(1) <<< (EFF_BITS - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAT_LO   = -SAT_HI - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD    = 3'd0,
        MODE_SUB    = 3'd1,
        MODE_SCALE  = 3'd2,
        MODE_DIVIDE = 3'd3,
        MODE_LENGTH = 3'd4,
        MODE_NORM   = 3'd5,
        MODE_CROSS  = 3'd6,
        MODE_DOT    = 3'd7
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK  = 2'd0,
        ST_SAT = 2'd1,
        ST_DZ  = 2'd2
    } status_t;

    typedef struct packed {
        logic [DW-1:0] val;
        logic          ov;
    } sat_t;

    // What one lane hands to the merge stage
    typedef struct packed {
        logic [DW-1:0]            vr;
        logic                     vov;
        logic signed [PROD_W-1:0] term;
        logic [DW-1:0]            a;
    } lane_t;

    // Per-item information carried alongside the long units
    typedef struct packed {
        mode_t                mode;
        logic [2:0][DW-1:0]   a;
        logic [DW-1:0]        s;
        logic [2:0][DW-1:0]   vr;
        logic [2:0]           vov;
        logic [DW-1:0]        sc;
        logic                 sc_ov;
        logic [LEN_W-1:0]     len;
    } side_t;

    // Clamp to the word range, flag overflow
    function automatic sat_t sat_acc(input logic signed [ACC_W-1:0] v);
        sat_t r;
        r.ov = 1'b0;
        if (v > SAT_HI) begin
            r.val = SAT_HI[DW-1:0];
            r.ov  = 1'b1;
        end else if (v < SAT_LO) begin
            r.val = SAT_LO[DW-1:0];
            r.ov  = 1'b1;
        end else begin
            r.val = v[DW-1:0];
        end
        return r;
    endfunction

    // Back to scale FRAC_BITS, nearest with ties upward
    function automatic logic signed [ACC_W-1:0] round_acc(input logic signed [ACC_W-1:0] v);
        return (v + RND_HALF) >>> FRAC_BITS;
    endfunction

endpackage

// File: sv/v3a_lane.sv
// One vector lane: two multipliers, then add/sub/scale/cross result for its component.
module v3a_lane (
    input  logic                        aclk,
    input  logic                        en,
    input  v3a_pkg::mode_t              mode,
    input  logic signed [v3a_pkg::DW-1:0] a_self,
    input  logic signed [v3a_pkg::DW-1:0] a_n1,
    input  logic signed [v3a_pkg::DW-1:0] a_n2,
    input  logic signed [v3a_pkg::DW-1:0] b_self,
    input  logic signed [v3a_pkg::DW-1:0] b_n1,
    input  logic signed [v3a_pkg::DW-1:0] b_n2,
    input  logic signed [v3a_pkg::DW-1:0] s,
    output v3a_pkg::lane_t              lane_o
);
    import v3a_pkg::*;

    logic signed [DW-1:0]     op0, op1;
    logic signed [PROD_W-1:0] m0, m1;
    logic signed [PROD_W-1:0] p0_reg, p1_reg;
    logic signed [DW-1:0]     a_reg, b_reg;
    mode_t                    mode_reg;
    logic signed [ACC_W-1:0]  ae, be, p0x, p1x;
    sat_t                     res;
    lane_t                    lane_reg, lane_next;

    // Operand select for the shared multiplier
    always_comb begin
        unique case (mode)
            MODE_SCALE: begin
                op0 = a_self;
                op1 = s;
            end
            MODE_CROSS: begin
                op0 = a_n1;
                op1 = b_n2;
            end
            MODE_LENGTH, MODE_NORM: begin
                op0 = a_self;
                op1 = a_self;
            end
            default: begin
                op0 = a_self;
                op1 = b_self;
            end
        endcase
    end

    assign m0 = op0 * op1;
    assign m1 = a_n2 * b_n1;

    // Stage 1: products
    always_ff @(posedge aclk) begin
        if (en) begin
            p0_reg   <= m0;
            p1_reg   <= m1;
            mode_reg <= mode;
            a_reg    <= a_self;
            b_reg    <= b_self;
        end
    end

    assign ae  = ACC_W'(a_reg);
    assign be  = ACC_W'(b_reg);
    assign p0x = ACC_W'(p0_reg);
    assign p1x = ACC_W'(p1_reg);

    // Lane result for the element-wise operations
    always_comb begin
        unique case (mode_reg)
            MODE_ADD:   res = sat_acc(ae + be);
            MODE_SUB:   res = sat_acc(ae - be);
            MODE_SCALE: res = sat_acc(round_acc(p0x));
            MODE_CROSS: res = sat_acc(round_acc(p0x - p1x));
            default:    res = '0;
        endcase
    end

    always_comb begin
        lane_next.vr   = res.val;
        lane_next.vov  = res.ov;
        lane_next.term = p0_reg;
        lane_next.a    = a_reg;
    end

    // Stage 2
    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
        end
    end

    assign lane_o = lane_reg;

endmodule

// File: sv/v3a_merge.sv
// Merge stage: sums the lane terms for dot product and sum of squares.
module v3a_merge (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      v_in,
    input  v3a_pkg::mode_t            mode,
    input  logic [v3a_pkg::DW-1:0]    s,
    input  v3a_pkg::lane_t            lane0,
    input  v3a_pkg::lane_t            lane1,
    input  v3a_pkg::lane_t            lane2,
    output logic                      v_out,
    output v3a_pkg::side_t            side_o,
    output logic [v3a_pkg::SQ_IN_W-1:0] sq_o
);
    import v3a_pkg::*;

    logic                    v1_reg, v2_reg;
    logic signed [ACC_W-1:0] sum_reg;
    side_t                   side1_reg, side2_reg;
    side_t                   side1_next, side2_next;
    logic [SQ_IN_W-1:0]      sq_reg;
    sat_t                    dot;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= v_in;
            v2_reg <= v1_reg;
        end
    end

    always_comb begin
        side1_next.mode  = mode;
        side1_next.a     = {lane2.a, lane1.a, lane0.a};
        side1_next.s     = s;
        side1_next.vr    = {lane2.vr, lane1.vr, lane0.vr};
        side1_next.vov   = {lane2.vov, lane1.vov, lane0.vov};
        side1_next.sc    = '0;
        side1_next.sc_ov = 1'b0;
        side1_next.len   = '0;
    end

    // First beat: three-term sum
    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg   <= ACC_W'($signed(lane0.term)) + ACC_W'($signed(lane1.term))
                       + ACC_W'($signed(lane2.term));
            side1_reg <= side1_next;
        end
    end

    assign dot = sat_acc(round_acc(sum_reg));

    always_comb begin
        side2_next       = side1_reg;
        side2_next.sc    = dot.val;
        side2_next.sc_ov = dot.ov;
    end

    // Second beat: rounded dot product, squares for the root
    always_ff @(posedge aclk) begin
        if (en) begin
            side2_reg <= side2_next;
            sq_reg    <= sum_reg[SQ_IN_W-1:0];
        end
    end

    assign v_out  = v2_reg;
    assign side_o = side2_reg;
    assign sq_o   = sq_reg;

endmodule

// File: sv/v3a_sqrt.sv
// Pipelined integer square root, two radicand bits per stage, rounded to nearest.
module v3a_sqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        v_in,
    input  v3a_pkg::side_t              side_in,
    input  logic [v3a_pkg::SQ_IN_W-1:0] x_in,
    output logic                        v_out,
    output v3a_pkg::side_t              side_out
);
    import v3a_pkg::*;

    logic                  v_reg    [SQ_STEPS];
    logic [SQ_IN_W-1:0]    x_reg    [SQ_STEPS];
    logic [SQ_REM_W-1:0]   rem_reg  [SQ_STEPS];
    logic [SQ_STEPS-1:0]   root_reg [SQ_STEPS];
    side_t                 side_reg [SQ_STEPS];
    logic                  out_v_reg;
    side_t                 out_side_reg, out_side_next;
    logic [SQ_STEPS-1:0]   root_f;
    logic [SQ_REM_W-1:0]   rem_f;

    genvar k;
    generate
        for (k = 0; k < SQ_STEPS; k++) begin : g_step
            logic [SQ_IN_W-1:0]  x_prev;
            logic [SQ_REM_W-1:0] rem_prev, rs, t;
            logic [SQ_STEPS-1:0] root_prev;
            side_t               side_prev;
            logic                v_prev;

            if (k == 0) begin : g_first
                assign x_prev    = x_in;
                assign rem_prev  = '0;
                assign root_prev = '0;
                assign side_prev = side_in;
                assign v_prev    = v_in;
            end else begin : g_next
                assign x_prev    = x_reg[k-1];
                assign rem_prev  = rem_reg[k-1];
                assign root_prev = root_reg[k-1];
                assign side_prev = side_reg[k-1];
                assign v_prev    = v_reg[k-1];
            end

            // Bring down the next two radicand bits, try 4*root+1
            assign rs = {rem_prev[SQ_REM_W-3:0], x_prev[SQ_IN_W-1 -: 2]};
            assign t  = SQ_REM_W'({root_prev, 2'b01});

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[k] <= 1'b0;
                end else if (en) begin
                    v_reg[k] <= v_prev;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    x_reg[k]    <= x_prev << 2;
                    side_reg[k] <= side_prev;
                    if (rs >= t) begin
                        rem_reg[k]  <= rs - t;
                        root_reg[k] <= {root_prev[SQ_STEPS-2:0], 1'b1};
                    end else begin
                        rem_reg[k]  <= rs;
                        root_reg[k] <= {root_prev[SQ_STEPS-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign root_f = root_reg[SQ_STEPS-1];
    assign rem_f  = rem_reg[SQ_STEPS-1];

    // Round up when the remainder exceeds the root
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (en) begin
            out_v_reg <= v_reg[SQ_STEPS-1];
        end
    end

    always_comb begin
        out_side_next     = side_reg[SQ_STEPS-1];
        out_side_next.len = LEN_W'(root_f) + LEN_W'(rem_f > SQ_REM_W'(root_f));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_side_reg <= out_side_next;
        end
    end

    assign v_out    = out_v_reg;
    assign side_out = out_side_reg;

endmodule

// File: sv/v3a_div.sv
// Three-lane pipelined restoring divider for divide and normalize, one quotient bit per stage.
module v3a_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          v_in,
    input  v3a_pkg::side_t                side_in,
    output logic                          v_out,
    output v3a_pkg::side_t                side_out,
    output logic [2:0][v3a_pkg::DW-1:0]   q_out,
    output logic [2:0]                    ov_out,
    output logic                          dz_out
);
    import v3a_pkg::*;

    // Prep stage signals
    logic signed [DV_W-1:0] s_ext;
    logic [DV_W-1:0]        s_abs, d_sel;
    logic [2:0][DVD_W-1:0]  n_init;
    logic [2:0]             neg_init;

    logic                   p_v_reg;
    side_t                  p_side_reg;
    logic [DV_W-1:0]        p_d_reg;
    logic                   p_dz_reg;
    logic [2:0][DVD_W-1:0]  p_n_reg;
    logic [2:0]             p_neg_reg;

    // Step stage registers
    logic                   v_reg    [DVD_W];
    side_t                  side_reg [DVD_W];
    logic [DV_W-1:0]        d_reg    [DVD_W];
    logic                   dz_reg   [DVD_W];
    logic [2:0]             neg_reg  [DVD_W];
    logic [2:0][DVD_W-1:0]  n_reg    [DVD_W];
    logic [2:0][DVD_W-1:0]  q_reg    [DVD_W];
    logic [2:0][DREM_W-1:0] rem_reg  [DVD_W];

    // Final stage
    logic                   out_v_reg;
    side_t                  out_side_reg;
    logic [2:0][DW-1:0]     out_q_reg;
    logic [2:0]             out_ov_reg;
    logic                   out_dz_reg;
    sat_t [2:0]             fin;

    // Divisor magnitude and rounded dividends
    assign s_ext = DV_W'($signed(side_in.s));
    assign s_abs = (s_ext < 0) ? DV_W'(-s_ext) : DV_W'(s_ext);
    assign d_sel = (side_in.mode == MODE_DIVIDE) ? s_abs : side_in.len;

    always_comb begin
        logic [DW-1:0] a_abs;
        for (int l = 0; l < 3; l++) begin
            a_abs       = side_in.a[l][DW-1] ? (~side_in.a[l] + DW'(1)) : side_in.a[l];
            n_init[l]   = (DVD_W'(a_abs) << FRAC_BITS) + DVD_W'(d_sel >> 1);
            neg_init[l] = side_in.a[l][DW-1]
                        ^ ((side_in.mode == MODE_DIVIDE) && side_in.s[DW-1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_v_reg <= 1'b0;
        end else if (en) begin
            p_v_reg <= v_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_side_reg <= side_in;
            p_d_reg    <= d_sel;
            p_dz_reg   <= (d_sel == '0);
            p_n_reg    <= n_init;
            p_neg_reg  <= neg_init;
        end
    end

    genvar k;
    generate
        for (k = 0; k < DVD_W; k++) begin : g_step
            logic                   v_prev, dz_prev;
            side_t                  side_prev;
            logic [DV_W-1:0]        d_prev;
            logic [2:0]             neg_prev;
            logic [2:0][DVD_W-1:0]  n_prev, q_prev, n_nx, q_nx;
            logic [2:0][DREM_W-1:0] rem_prev, rem_nx;

            if (k == 0) begin : g_first
                assign v_prev    = p_v_reg;
                assign dz_prev   = p_dz_reg;
                assign side_prev = p_side_reg;
                assign d_prev    = p_d_reg;
                assign neg_prev  = p_neg_reg;
                assign n_prev    = p_n_reg;
                assign q_prev    = '0;
                assign rem_prev  = '0;
            end else begin : g_next
                assign v_prev    = v_reg[k-1];
                assign dz_prev   = dz_reg[k-1];
                assign side_prev = side_reg[k-1];
                assign d_prev    = d_reg[k-1];
                assign neg_prev  = neg_reg[k-1];
                assign n_prev    = n_reg[k-1];
                assign q_prev    = q_reg[k-1];
                assign rem_prev  = rem_reg[k-1];
            end

            // One trial subtraction per lane
            always_comb begin
                logic [DREM_W-1:0] rs;
                for (int l = 0; l < 3; l++) begin
                    rs      = {rem_prev[l][DREM_W-2:0], n_prev[l][DVD_W-1]};
                    n_nx[l] = n_prev[l] << 1;
                    if (rs >= DREM_W'(d_prev)) begin
                        rem_nx[l] = rs - DREM_W'(d_prev);
                        q_nx[l]   = {q_prev[l][DVD_W-2:0], 1'b1};
                    end else begin
                        rem_nx[l] = rs;
                        q_nx[l]   = {q_prev[l][DVD_W-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[k] <= 1'b0;
                end else if (en) begin
                    v_reg[k] <= v_prev;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    side_reg[k] <= side_prev;
                    d_reg[k]    <= d_prev;
                    dz_reg[k]   <= dz_prev;
                    neg_reg[k]  <= neg_prev;
                    n_reg[k]    <= n_nx;
                    q_reg[k]    <= q_nx;
                    rem_reg[k]  <= rem_nx;
                end
            end
        end
    endgenerate

    // Apply sign and saturate
    always_comb begin
        logic signed [ACC_W-1:0] qx;
        for (int l = 0; l < 3; l++) begin
            qx     = ACC_W'(q_reg[DVD_W-1][l]);
            fin[l] = sat_acc(neg_reg[DVD_W-1][l] ? -qx : qx);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (en) begin
            out_v_reg <= v_reg[DVD_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_side_reg <= side_reg[DVD_W-1];
            out_dz_reg   <= dz_reg[DVD_W-1];
            out_q_reg    <= {fin[2].val, fin[1].val, fin[0].val};
            out_ov_reg   <= {fin[2].ov, fin[1].ov, fin[0].ov};
        end
    end

    assign v_out    = out_v_reg;
    assign side_out = out_side_reg;
    assign q_out    = out_q_reg;
    assign ov_out   = out_ov_reg;
    assign dz_out   = out_dz_reg;

endmodule

// File: sv/vector3_alu_top.sv
// Top level of the three-component fixed-point vector unit.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tdata a_x,a_y,a_z,b_x,b_y,b_z,scalar; tuser mode
//  m_      | out | m_tvalid/m_tready  | tdata r_x,r_y,r_z,scalar_out; tuser status
//
// One beat is accepted per cycle while s_tready is high; every operation passes from input
// to output through the lanes, the merge, the 32-stage square root and the 49-stage divider lanes.
// All stages advance together whenever the output register is empty or being
// taken, so a stall at m_ holds the whole pipe and drops s_tready.
// Reset (aresetn low, synchronous) clears every stage valid bit.
module vector3_alu_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, scalar_in (32 bits each, lowest first)
    input  logic [v3a_pkg::S_TDATA_W-1:0]   s_tdata,
    // mode
    input  logic [v3a_pkg::MODE_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // r_x, r_y, r_z, scalar_out (32 bits each, lowest first)
    output logic [v3a_pkg::M_TDATA_W-1:0]   m_tdata,
    // status
    output logic [v3a_pkg::STAT_W-1:0]      m_tuser
);
    import v3a_pkg::*;

    logic                      adv;
    mode_t                     in_mode;
    logic signed [DW-1:0]      a [3];
    logic signed [DW-1:0]      b [3];
    logic signed [DW-1:0]      s_in;
    lane_t                     lane [3];

    logic                      v1_reg, v2_reg;
    mode_t                     mode1_reg, mode2_reg;
    logic [DW-1:0]             s1_reg, s2_reg;

    logic                      mg_v, sq_v, dv_v;
    side_t                     mg_side, sq_side, dv_side;
    logic [SQ_IN_W-1:0]        mg_sq;
    logic [2:0][DW-1:0]        dv_q;
    logic [2:0]                dv_ov;
    logic                      dv_dz;

    logic [2:0][DW-1:0]        r_fin;
    logic [DW-1:0]             sc_fin;
    status_t                   st_fin;
    sat_t                      len_sat;

    logic                      m_valid_reg;
    logic [M_TDATA_W-1:0]      m_data_reg;
    status_t                   m_stat_reg;

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    // Unpack the input beat
    assign in_mode = mode_t'(s_tuser);
    assign s_in    = s_tdata[6*DW +: DW];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a[i] = s_tdata[i*DW +: DW];
            b[i] = s_tdata[(i+3)*DW +: DW];
        end
    end

    // Lane control alongside the lane stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mode1_reg <= in_mode;
            mode2_reg <= mode1_reg;
            s1_reg    <= s_in;
            s2_reg    <= s1_reg;
        end
    end

    genvar i;
    generate
        for (i = 0; i < 3; i++) begin : g_lane
            v3a_lane u_lane (
                .aclk   (aclk),
                .en     (adv),
                .mode   (in_mode),
                .a_self (a[i]),
                .a_n1   (a[(i+1)%3]),
                .a_n2   (a[(i+2)%3]),
                .b_self (b[i]),
                .b_n1   (b[(i+1)%3]),
                .b_n2   (b[(i+2)%3]),
                .s      (s_in),
                .lane_o (lane[i])
            );
        end
    endgenerate

    v3a_merge u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .v_in    (v2_reg),
        .mode    (mode2_reg),
        .s       (s2_reg),
        .lane0   (lane[0]),
        .lane1   (lane[1]),
        .lane2   (lane[2]),
        .v_out   (mg_v),
        .side_o  (mg_side),
        .sq_o    (mg_sq)
    );

    v3a_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .v_in     (mg_v),
        .side_in  (mg_side),
        .x_in     (mg_sq),
        .v_out    (sq_v),
        .side_out (sq_side)
    );

    v3a_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .v_in     (sq_v),
        .side_in  (sq_side),
        .v_out    (dv_v),
        .side_out (dv_side),
        .q_out    (dv_q),
        .ov_out   (dv_ov),
        .dz_out   (dv_dz)
    );

    assign len_sat = sat_acc(ACC_W'(dv_side.len));

    // Pick the result for the operation
    always_comb begin
        r_fin  = '0;
        sc_fin = '0;
        st_fin = ST_OK;
        unique case (dv_side.mode)
            MODE_ADD, MODE_SUB, MODE_SCALE, MODE_CROSS: begin
                r_fin  = dv_side.vr;
                st_fin = (|dv_side.vov) ? ST_SAT : ST_OK;
            end
            MODE_DIVIDE, MODE_NORM: begin
                if (dv_dz) begin
                    st_fin = ST_DZ;
                end else begin
                    r_fin  = dv_q;
                    st_fin = (|dv_ov) ? ST_SAT : ST_OK;
                end
            end
            MODE_LENGTH: begin
                sc_fin = len_sat.val;
                st_fin = len_sat.ov ? ST_SAT : ST_OK;
            end
            default: begin
                sc_fin = dv_side.sc;
                st_fin = dv_side.sc_ov ? ST_SAT : ST_OK;
            end
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= dv_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= {sc_fin, r_fin[2], r_fin[1], r_fin[0]};
            m_stat_reg <= st_fin;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_stat_reg;

    // Checks
    a_dz_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == ST_DZ)) |-> (m_tdata == '0))
        else $error("division-by-zero beat carries non-zero data");

    a_reset_empty : assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_stall : assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

endmodule
